@@ hw/rtl/hrf_pkg.sv @@
// ----------------------------------------------------------------------------
// hrf_pkg
// Types and constants shared by the HTTP response framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

  localparam int unsigned HeaderCapacity = 2048;
  localparam int unsigned HdrCntW = 12;
  localparam logic [9:0] StatusMax = 10'd599;
  localparam logic [9:0] StatusSat = 10'd600;

  // register addresses
  localparam logic [1:0] REG_MAX_LEN = 2'd0;

  // opcodes
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_CLOSE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_STATUS   = 4'd1;
  localparam logic [3:0] ERR_CODE     = 4'd2;
  localparam logic [3:0] ERR_LEN      = 4'd3;
  localparam logic [3:0] ERR_HDR_LONG = 4'd4;
  localparam logic [3:0] ERR_LEN_MAX  = 4'd5;
  localparam logic [3:0] ERR_BODY_MAX = 4'd6;
  localparam logic [3:0] ERR_BODY_LEN = 4'd7;
  localparam logic [3:0] ERR_CLOSED   = 4'd8;

  // line matcher positions
  localparam logic [4:0] LS_WS   = 5'd15;
  localparam logic [4:0] LS_DIG  = 5'd16;
  localparam logic [4:0] LS_SKIP = 5'd18;
  localparam logic [4:0] ST_REST = 5'd11;

  typedef enum logic [4:0] {
    PH_STATUS = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_FAIL   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       headers_done;
    logic [9:0] status_code;
    logic [31:0] content_length;
    logic       has_content_length;
    logic [31:0] body_received;
    logic       done_res;
    logic       success;
    logic [3:0] error_code;
  } result_t;

  function automatic logic [7:0] cl_char(input logic [4:0] i);
    case (i)
      5'd0:  cl_char = "C";
      5'd1:  cl_char = "o";
      5'd2:  cl_char = "n";
      5'd3:  cl_char = "t";
      5'd4:  cl_char = "e";
      5'd5:  cl_char = "n";
      5'd6:  cl_char = "t";
      5'd7:  cl_char = "-";
      5'd8:  cl_char = "L";
      5'd9:  cl_char = "e";
      5'd10: cl_char = "n";
      5'd11: cl_char = "g";
      5'd12: cl_char = "t";
      5'd13: cl_char = "h";
      5'd14: cl_char = ":";
      default: cl_char = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] http_char(input logic [4:0] i);
    case (i)
      5'd0: http_char = "H";
      5'd1: http_char = "T";
      5'd2: http_char = "T";
      5'd3: http_char = "P";
      5'd4: http_char = "/";
      default: http_char = 8'd0;
    endcase
  endfunction

endpackage

@@ hw/rtl/http_response_framer.sv @@
// Each result is registered into the output queue as its input is taken.
// Throughput: one input transfer per cycle while the output queue is not full.
// A two-entry output buffer keeps input flowing while a result waits.
// Reset: synchronous; clears parser state, max_body_len returns to 65536.
// ----------------------------------------------------------------------------
// http_response_framer
// Byte-serial HTTP response header parser and body framer.
// ----------------------------------------------------------------------------
module http_response_framer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [1:0] opcode, [9:2] in_byte, rest zero
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // body_valid, body_byte, headers_done, status_code,
                                  // content_length, has_content_length,
                                  // body_received, done_res, success, error_code,
                                  // rest zero
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import hrf_pkg::*;

  logic [31:0] max_body_len;
  result_t     res;
  result_t     buf0, buf1;
  logic [1:0]  count;
  logic        s_xfer, m_xfer;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_LEN) ? max_body_len : 32'd0;

  // config register
  always_ff @(posedge clk) begin
    if (rst) max_body_len <= 32'd65536;
    else if (psel && penable && pwrite && paddr == REG_MAX_LEN) max_body_len <= pwdata;
  end

  assign s_tready = (count != 2'd2);
  assign s_xfer   = s_tvalid && s_tready;
  assign m_tvalid = (count != 2'd0);
  assign m_xfer   = m_tvalid && m_tready;

  hrf_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (s_xfer),
    .opcode       (s_tdata[1:0]),
    .in_byte      (s_tdata[9:2]),
    .max_body_len (max_body_len),
    .res          (res)
  );

  // two-entry output queue, head in buf0
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, s_xfer} - {1'b0, m_xfer};
    end
  end

  always_ff @(posedge clk) begin
    if (m_xfer) begin
      buf0 <= (count == 2'd2) ? buf1 : res;
      if (s_xfer) buf1 <= res;
    end else if (s_xfer) begin
      if (count == 2'd0) buf0 <= res;
      else buf1 <= res;
    end
  end

  assign m_tdata = {5'd0, buf0.error_code, buf0.success, buf0.done_res,
                    buf0.body_received, buf0.has_content_length, buf0.content_length,
                    buf0.status_code, buf0.headers_done, buf0.body_byte,
                    buf0.body_valid};

endmodule

@@ hw/rtl/hrf_core.sv @@
// ----------------------------------------------------------------------------
// hrf_core
// Per-byte parser state and result formation, one event per cycle while step is high.
// ----------------------------------------------------------------------------
module hrf_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        opcode,
  input  logic [7:0]        in_byte,
  input  logic [31:0]       max_body_len,
  output hrf_pkg::result_t  res
);
  import hrf_pkg::*;

  phase_t               phase, phase_next;
  logic [HdrCntW-1:0]   header_count, header_count_next;
  logic [1:0]           term_match, term_match_next;
  logic [4:0]           line_state, line_state_next;
  logic [9:0]           status_accum, status_accum_next;
  logic [32:0]          length_accum, length_accum_next;
  logic                 length_seen, length_seen_next;
  logic [31:0]          body_count, body_count_next;
  logic [3:0]           error_state, error_state_next;
  logic                 bv, hd;

  logic       is_dig, is_blank;
  logic [3:0] dval;
  logic [13:0] st_mul;
  logic [36:0] len_mul;
  logic [32:0] body_inc;

  assign is_dig   = (in_byte >= "0") && (in_byte <= "9");
  assign is_blank = (in_byte == " ") || (in_byte == 8'h09);
  assign dval     = 4'(in_byte - "0");
  assign st_mul   = {4'd0, status_accum} * 14'd10 + {10'd0, dval};
  assign len_mul  = {4'd0, length_accum} * 37'd10 + {33'd0, dval};
  assign body_inc = {1'b0, body_count} + 33'd1;

  // next-state logic
  always_comb begin
    logic crlf, term;
    logic [3:0] err;
    phase_next        = phase;
    header_count_next = header_count;
    term_match_next   = term_match;
    line_state_next   = line_state;
    status_accum_next = status_accum;
    length_accum_next = length_accum;
    length_seen_next  = length_seen;
    body_count_next   = body_count;
    error_state_next  = error_state;
    bv = 1'b0;
    hd = 1'b0;
    crlf = 1'b0;
    term = 1'b0;
    err = ERR_NONE;
    if (opcode == OP_RESTART) begin
      phase_next        = PH_STATUS;
      header_count_next = '0;
      term_match_next   = '0;
      line_state_next   = '0;
      status_accum_next = '0;
      length_accum_next = '0;
      length_seen_next  = 1'b0;
      body_count_next   = '0;
      error_state_next  = ERR_NONE;
    end else if (opcode == OP_CLOSE) begin
      if (phase == PH_BODY) begin
        phase_next = PH_DONE;
        if (length_seen) error_state_next = ERR_CLOSED;
      end else if (phase == PH_STATUS || phase == PH_HEADER) begin
        error_state_next = ERR_CLOSED;
        phase_next = PH_FAIL;
      end
    end else if (opcode == OP_BYTE) begin
      if (phase == PH_STATUS || phase == PH_HEADER) begin
        if (header_count >= HdrCntW'(HeaderCapacity)) begin
          error_state_next = ERR_HDR_LONG;
          phase_next = PH_FAIL;
        end else begin
          header_count_next = header_count + 1'b1;
          if (in_byte == 8'h0d) begin
            term_match_next = (term_match == 2'd2) ? 2'd3 : 2'd1;
          end else if (in_byte == 8'h0a) begin
            crlf = (term_match == 2'd1) || (term_match == 2'd3);
            term = (term_match == 2'd3);
            term_match_next = (term_match == 2'd1) ? 2'd2 : 2'd0;
          end else begin
            term_match_next = 2'd0;
          end
          if (phase == PH_STATUS) begin
            if (line_state < 5'd5) begin
              if (in_byte == http_char(line_state)) line_state_next = line_state + 5'd1;
              else begin err = ERR_STATUS; line_state_next = ST_REST; end
            end else if (line_state == 5'd5 || line_state == 5'd7) begin
              if (is_dig) line_state_next = line_state + 5'd1;
              else begin err = ERR_STATUS; line_state_next = ST_REST; end
            end else if (line_state == 5'd6) begin
              if (in_byte == ".") line_state_next = 5'd7;
              else if (!is_dig) begin err = ERR_STATUS; line_state_next = ST_REST; end
            end else if (line_state == 5'd8) begin
              if (is_blank) line_state_next = 5'd9;
              else if (!is_dig) begin err = ERR_STATUS; line_state_next = ST_REST; end
            end else if (line_state == 5'd9) begin
              if (is_dig) begin
                status_accum_next = {6'd0, dval};
                line_state_next = 5'd10;
              end else if (!is_blank) begin
                err = ERR_STATUS; line_state_next = ST_REST;
              end
            end else if (line_state == 5'd10) begin
              if (is_dig) begin
                status_accum_next = (st_mul > 14'(StatusMax)) ? StatusSat : st_mul[9:0];
              end else begin
                if (status_accum > StatusMax) err = ERR_CODE;
                line_state_next = ST_REST;
              end
            end
          end else begin
            if (line_state < 5'd15) begin
              if (in_byte == cl_char(line_state)) line_state_next = line_state + 5'd1;
              else line_state_next = LS_SKIP;
            end else if (line_state == LS_WS) begin
              if (is_dig) begin
                length_accum_next = {29'd0, dval};
                line_state_next = LS_DIG;
              end else if (!is_blank) begin
                err = ERR_LEN; line_state_next = LS_SKIP;
              end
            end else if (line_state == LS_DIG) begin
              if (is_dig) begin
                if (len_mul[36:32] != 5'd0) begin
                  length_accum_next = {1'b1, 32'd0};
                  err = ERR_LEN;
                end else begin
                  length_accum_next = len_mul[32:0];
                end
              end else begin
                if (in_byte == 8'h0d) length_seen_next = 1'b1;
                else err = ERR_LEN;
                line_state_next = LS_SKIP;
              end
            end
          end
          if (error_state == ERR_NONE) error_state_next = err;
          if (crlf) begin
            phase_next = PH_HEADER;
            line_state_next = '0;
          end
          if (term) begin
            if (error_state_next != ERR_NONE) begin
              phase_next = PH_FAIL;
            end else if (length_seen_next &&
                         length_accum_next > {1'b0, max_body_len}) begin
              error_state_next = ERR_LEN_MAX;
              phase_next = PH_FAIL;
            end else begin
              hd = 1'b1;
              phase_next = (length_seen_next && length_accum_next == '0) ? PH_DONE : PH_BODY;
            end
          end
        end
      end else if (phase == PH_BODY) begin
        if (body_count >= max_body_len) begin
          error_state_next = ERR_BODY_MAX;
          phase_next = PH_DONE;
        end else if (length_seen && body_inc > length_accum) begin
          error_state_next = ERR_BODY_LEN;
          phase_next = PH_DONE;
        end else begin
          bv = 1'b1;
          body_count_next = body_inc[31:0];
          if (length_seen && body_inc == length_accum) phase_next = PH_DONE;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STATUS;
      header_count <= '0;
      term_match   <= '0;
      line_state   <= '0;
      status_accum <= '0;
      length_accum <= '0;
      length_seen  <= 1'b0;
      body_count   <= '0;
      error_state  <= ERR_NONE;
    end else if (step) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      term_match   <= term_match_next;
      line_state   <= line_state_next;
      status_accum <= status_accum_next;
      length_accum <= length_accum_next;
      length_seen  <= length_seen_next;
      body_count   <= body_count_next;
      error_state  <= error_state_next;
    end
  end

  // result formed from next state
  always_comb begin
    logic acc, done;
    acc = (phase_next == PH_BODY) || (phase_next == PH_DONE);
    done = (phase_next == PH_FAIL) || (phase_next == PH_DONE);
    res.body_valid         = bv;
    res.body_byte          = bv ? in_byte : 8'd0;
    res.headers_done       = hd;
    res.status_code        = acc ? status_accum_next : 10'd0;
    res.content_length     = (acc && length_seen_next) ? length_accum_next[31:0] : 32'd0;
    res.has_content_length = acc && length_seen_next;
    res.body_received      = body_count_next;
    res.done_res           = done;
    res.success            = done && (error_state_next == ERR_NONE);
    res.error_code         = done ? error_state_next : ERR_NONE;
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HTTP response framer. A short table of directed
// events runs first, then randomized responses (well-formed with random
// content, plus corrupted bytes, close and restart events). Every output
// transfer is compared field by field against an in-bench parser model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hrf_pkg::*;

  localparam int TimeoutCycles = 500000;
  // unused opcode, must leave the parser untouched
  localparam logic [1:0] OP_NONE = 2'd3;

  // one expected output transfer
  typedef struct {
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        headers_done;
    logic [9:0]  status_code;
    logic [31:0] content_length;
    logic        has_content_length;
    logic [31:0] body_received;
    logic        done_res;
    logic        success;
    logic [3:0]  error_code;
  } rsp_t;

  // directed row: event, plus hand-written done/error where obvious
  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    bit         fixed;
    logic       done;
    logic [3:0] err;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata = '0;   // [1:0] opcode, [9:2] in_byte, rest zero
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;        // body_valid, body_byte, headers_done, status_code,
                                // content_length, has_content_length,
                                // body_received, done_res, success, error_code,
                                // rest zero
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [1:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  http_response_framer u_top (.*);

  // parser model state
  logic [31:0] mdl_max_len;
  phase_t      mdl_phase;
  int unsigned mdl_hdr_cnt;
  int unsigned mdl_term;
  int unsigned mdl_line;
  int unsigned mdl_status;
  logic [63:0] mdl_len;
  bit          mdl_len_seen;
  logic [31:0] mdl_body_cnt;
  logic [3:0]  mdl_err;

  rsp_t        frame_q[$];
  row_t        fixed_q[$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          items_sent = 0;
  int unsigned snd_pct = 0;
  int unsigned rcv_pct = 0;

  string http_pfx = "HTTP/";
  string cl_pfx = "Content-Length:";

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == " " || b == "\t";
  endfunction

  function automatic void note_err(logic [3:0] e);
    if (mdl_err == ERR_NONE) mdl_err = e;
  endfunction

  function automatic void clear_parser();
    mdl_phase = PH_STATUS;
    mdl_hdr_cnt = 0;
    mdl_term = 0;
    mdl_line = 0;
    mdl_status = 0;
    mdl_len = '0;
    mdl_len_seen = 0;
    mdl_body_cnt = '0;
    mdl_err = ERR_NONE;
  endfunction

  // status line matcher
  function automatic void status_char(logic [7:0] b);
    int unsigned v;
    if (mdl_line < 5) begin
      if (b == http_pfx[mdl_line]) mdl_line++;
      else begin note_err(ERR_STATUS); mdl_line = ST_REST; end
    end else if (mdl_line == 5 || mdl_line == 7) begin
      if (is_dig(b)) mdl_line++;
      else begin note_err(ERR_STATUS); mdl_line = ST_REST; end
    end else if (mdl_line == 6) begin
      if (b == ".") mdl_line = 7;
      else if (!is_dig(b)) begin note_err(ERR_STATUS); mdl_line = ST_REST; end
    end else if (mdl_line == 8) begin
      if (is_blank(b)) mdl_line = 9;
      else if (!is_dig(b)) begin note_err(ERR_STATUS); mdl_line = ST_REST; end
    end else if (mdl_line == 9) begin
      if (is_dig(b)) begin mdl_status = b - "0"; mdl_line = 10; end
      else if (!is_blank(b)) begin note_err(ERR_STATUS); mdl_line = ST_REST; end
    end else if (mdl_line == 10) begin
      if (is_dig(b)) begin
        v = mdl_status * 10 + (b - "0");
        mdl_status = (v > 599) ? 600 : v;
      end else begin
        if (mdl_status > 599) note_err(ERR_CODE);
        mdl_line = ST_REST;
      end
    end
  endfunction

  // Content-Length line matcher
  function automatic void header_char(logic [7:0] b);
    logic [63:0] v;
    if (mdl_line < 15) begin
      if (b == cl_pfx[mdl_line]) mdl_line++;
      else mdl_line = LS_SKIP;
    end else if (mdl_line == LS_WS) begin
      if (is_dig(b)) begin mdl_len = b - "0"; mdl_line = LS_DIG; end
      else if (!is_blank(b)) begin note_err(ERR_LEN); mdl_line = LS_SKIP; end
    end else if (mdl_line == LS_DIG) begin
      if (is_dig(b)) begin
        v = mdl_len * 10 + (b - "0");
        if (v >= 64'h1_0000_0000) begin v = 64'h1_0000_0000; note_err(ERR_LEN); end
        mdl_len = v;
      end else begin
        if (b == 8'h0d) mdl_len_seen = 1;
        else note_err(ERR_LEN);
        mdl_line = LS_SKIP;
      end
    end
  endfunction

  // next output transfer for one accepted event
  function automatic rsp_t predict_frame(logic [1:0] op, logic [7:0] b);
    rsp_t r;
    bit crlf, term, acc, fin;
    r = '{default: '0};
    if (op == OP_RESTART) begin
      clear_parser();
    end else if (op == OP_CLOSE) begin
      if (mdl_phase == PH_BODY) begin
        if (mdl_len_seen) mdl_err = ERR_CLOSED;
        mdl_phase = PH_DONE;
      end else if (mdl_phase == PH_STATUS || mdl_phase == PH_HEADER) begin
        mdl_err = ERR_CLOSED;
        mdl_phase = PH_FAIL;
      end
    end else if (op == OP_BYTE) begin
      if (mdl_phase == PH_STATUS || mdl_phase == PH_HEADER) begin
        if (mdl_hdr_cnt >= HeaderCapacity) begin
          mdl_err = ERR_HDR_LONG;
          mdl_phase = PH_FAIL;
        end else begin
          crlf = 0;
          term = 0;
          mdl_hdr_cnt++;
          if (b == 8'h0d) mdl_term = (mdl_term == 2) ? 3 : 1;
          else if (b == 8'h0a) begin
            crlf = mdl_term == 1 || mdl_term == 3;
            term = mdl_term == 3;
            mdl_term = (mdl_term == 1) ? 2 : 0;
          end else mdl_term = 0;
          if (mdl_phase == PH_STATUS) status_char(b);
          else header_char(b);
          if (crlf) begin mdl_phase = PH_HEADER; mdl_line = 0; end
          // end of header block
          if (term) begin
            if (mdl_err != ERR_NONE) mdl_phase = PH_FAIL;
            else if (mdl_len_seen && mdl_len > {32'd0, mdl_max_len}) begin
              mdl_err = ERR_LEN_MAX;
              mdl_phase = PH_FAIL;
            end else begin
              r.headers_done = 1;
              mdl_phase = (mdl_len_seen && mdl_len == 0) ? PH_DONE : PH_BODY;
            end
          end
        end
      end else if (mdl_phase == PH_BODY) begin
        if (mdl_body_cnt >= mdl_max_len) begin
          mdl_err = ERR_BODY_MAX;
          mdl_phase = PH_DONE;
        end else if (mdl_len_seen && {32'd0, mdl_body_cnt} + 1 > mdl_len) begin
          mdl_err = ERR_BODY_LEN;
          mdl_phase = PH_DONE;
        end else begin
          r.body_valid = 1;
          r.body_byte = b;
          mdl_body_cnt++;
          if (mdl_len_seen && {32'd0, mdl_body_cnt} == mdl_len) mdl_phase = PH_DONE;
        end
      end
    end
    acc = mdl_phase == PH_BODY || mdl_phase == PH_DONE;
    fin = mdl_phase == PH_FAIL || mdl_phase == PH_DONE;
    r.status_code = acc ? mdl_status[9:0] : '0;
    r.content_length = (acc && mdl_len_seen) ? mdl_len[31:0] : '0;
    r.has_content_length = acc && mdl_len_seen;
    r.body_received = mdl_body_cnt;
    r.done_res = fin;
    r.success = fin && mdl_err == ERR_NONE;
    r.error_code = fin ? mdl_err : ERR_NONE;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > TimeoutCycles) begin
      $display("http_response_framer regression: fail");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= rcv_pct);
  end

  // input transfers feed the model, output transfers are checked
  always @(posedge clk) begin
    rsp_t e;
    row_t fx;
    if (!rst && s_tvalid && s_tready) frame_q.push_back(predict_frame(s_tdata[1:0], s_tdata[9:2]));
    if (!rst && m_tvalid && m_tready) begin
      if (frame_q.size() == 0) begin
        $error("output transfer with nothing expected");
        fail_cnt++;
      end else begin
        e = frame_q.pop_front();
        check_field("body_valid", e.body_valid, m_tdata[0]);
        check_field("body_byte", e.body_byte, m_tdata[8:1]);
        check_field("headers_done", e.headers_done, m_tdata[9]);
        check_field("status_code", e.status_code, m_tdata[19:10]);
        check_field("content_length", e.content_length, m_tdata[51:20]);
        check_field("has_content_length", e.has_content_length, m_tdata[52]);
        check_field("body_received", e.body_received, m_tdata[84:53]);
        check_field("done_res", e.done_res, m_tdata[85]);
        check_field("success", e.success, m_tdata[86]);
        check_field("error_code", e.error_code, m_tdata[90:87]);
        if (fixed_q.size() != 0) begin
          fx = fixed_q.pop_front();
          if (fx.fixed) begin
            check_field("done_res", fx.done, m_tdata[85]);
            check_field("error_code", fx.err, m_tdata[90:87]);
          end
        end
      end
    end
  end

  // one input transfer, with random sender gaps
  task automatic send(input logic [1:0] op, input logic [7:0] b);
    while ($urandom_range(99) < snd_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, b, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // bytes of a string, each corrupted with the given odds
  task automatic send_text(input string txt, input int unsigned noise);
    logic [7:0] c;
    for (int i = 0; i < txt.len(); i++) begin
      c = txt[i];
      if ($urandom_range(999) < noise) c = 8'($urandom_range(255));
      send(OP_BYTE, c);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_MAX_LEN;
    pwdata <= v;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    mdl_max_len = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one randomized response, restart first
  task automatic send_response();
    string ver, cl_line, sep;
    int unsigned noise, body_n, pick;
    logic [31:0] len_v;
    noise = ($urandom_range(3) == 0) ? 25 : 0;
    send(OP_RESTART, 8'($urandom_range(255)));
    sep = ($urandom_range(1) != 0) ? " " : "\t";
    ver = $sformatf("HTTP/%0d.%0d%s", $urandom_range(9), $urandom_range(12), sep);
    pick = $urandom_range(9);
    if (pick == 0) send_text({ver, $sformatf("%0d", $urandom_range(999, 600))}, noise);
    else if (pick == 1) send_text({ver, "\r"}, noise);
    else send_text({ver, $sformatf("%0d", $urandom_range(599, 100))}, noise);
    send_text("\r\n", noise);
    len_v = $urandom_range(16);
    for (int h = $urandom_range(3); h > 0; h--) begin
      pick = $urandom_range(19);
      len_v = (pick == 0) ? 32'd0 : $urandom_range(16);
      case (pick)
        1: cl_line = "Content-Length: 99999999999";
        2: cl_line = "Content-Length: -5";
        3: cl_line = "Content-Length: 4294967295";
        4: cl_line = $sformatf("content-length: %0d", len_v);
        5: cl_line = $sformatf("Content-Length: %0dx", len_v);
        6: cl_line = "X-Tag: abc";
        7: cl_line = "Content-Length:\t \r";
        default: cl_line = $sformatf("Content-Length:%s%0d", sep, len_v);
      endcase
      send_text({cl_line, "\r\n"}, noise);
    end
    send_text("\r\n", noise);
    body_n = $urandom_range(len_v + 3);
    for (int k = 0; k < body_n; k++) begin
      if ($urandom_range(19) == 0) send(OP_NONE, 8'($urandom_range(255)));
      send(OP_BYTE, 8'($urandom_range(255)));
    end
    if ($urandom_range(1) != 0) send(OP_CLOSE, 8'($urandom_range(255)));
  endtask

  row_t dir_tbl[$];
  logic [31:0] max_set[4] = '{32'hFFFF_FFFF, 32'd12, 32'd0, 32'd1};
  int          seg_items[4] = '{250, 250, 125, 125};
  string       line_a = "HTTP/1.0 7\r\n\r\n";

  initial begin
    mdl_max_len = 32'd65536;
    clear_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: early close, no-op opcode, minimal response without length
    dir_tbl.push_back('{OP_RESTART, 8'h00, 1, 1'b0, ERR_NONE});
    dir_tbl.push_back('{OP_NONE, 8'hff, 1, 1'b0, ERR_NONE});
    dir_tbl.push_back('{OP_CLOSE, 8'h00, 1, 1'b1, ERR_CLOSED});
    dir_tbl.push_back('{OP_BYTE, "x", 1, 1'b1, ERR_CLOSED});
    dir_tbl.push_back('{OP_RESTART, 8'hff, 1, 1'b0, ERR_NONE});
    for (int i = 0; i < line_a.len(); i++) dir_tbl.push_back('{OP_BYTE, line_a[i], 0, 0, 0});
    dir_tbl.push_back('{OP_BYTE, 8'hff, 0, 0, 0});
    dir_tbl.push_back('{OP_BYTE, 8'h00, 0, 0, 0});
    dir_tbl.push_back('{OP_CLOSE, 8'h00, 1, 1'b1, ERR_NONE});
    dir_tbl.push_back('{OP_RESTART, 8'h00, 1, 1'b0, ERR_NONE});
    dir_tbl.push_back('{OP_CLOSE, 8'h00, 1, 1'b1, ERR_CLOSED});
    foreach (dir_tbl[i]) begin
      fixed_q.push_back(dir_tbl[i]);
      send(dir_tbl[i].op, dir_tbl[i].data);
    end
    drain();

    // random responses over several limits and idling patterns
    for (int s = 0; s < 4; s++) begin
      write_max_len(max_set[s]);
      snd_pct = (s == 0) ? 33 : (s == 1) ? 78 : 0;
      rcv_pct = (s == 0) ? 78 : (s == 1) ? 33 : 0;
      items_sent = 0;
      while (items_sent < seg_items[s]) send_response();
      drain();
    end

    if (fail_cnt == 0) begin
      $display("http_response_framer regression: pass");
    end else begin
      $display("http_response_framer regression: fail");
    end
    $finish;
  end

endmodule
